@@ sv/bpv_pkg.sv @@
`timescale 1ns / 1ps
// Package for the binding path validator: parse phases, character codes and
// character-class helpers. It depends on nothing else.
package bpv_pkg;

   localparam int unsigned CH_W = 8;

   localparam logic [CH_W-1:0] CH_LOOP  = 8'h24;
   localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CH_W-1:0] CH_OPEN  = 8'h5B;
   localparam logic [CH_W-1:0] CH_CLOSE = 8'h5D;
   localparam logic [CH_W-1:0] CH_UNDER = 8'h5F;

   // Item kinds on the request channel.
   localparam logic ACT_CHAR = 1'b0;
   localparam logic ACT_END  = 1'b1;

   typedef enum logic [2:0] {
      PH_START     = 3'd0,
      PH_DOLLAR    = 3'd1,
      PH_AFTER_DOT = 3'd2,
      PH_SEGMENT   = 3'd3,
      PH_IDX_OPEN  = 3'd4,
      PH_IDX_DIGIT = 3'd5,
      PH_IDX_IDENT = 3'd6,
      PH_CLOSED    = 3'd7
   } phase_type;

   typedef struct packed {
      logic      legal;
      phase_type phase;
   } step_type;

   function automatic logic is_letter(input logic [CH_W-1:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_digit(input logic [CH_W-1:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_id_first(input logic [CH_W-1:0] c);
      return is_letter(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_id_rest(input logic [CH_W-1:0] c);
      return is_letter(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

endpackage

@@ sv/bpv_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the binding path validator: the request
// channel carries path characters and end marks, the response channel verdicts.
interface bpv_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] ch;

   modport source (output valid, output action, output ch, input ready);
   modport sink   (input valid, input action, input ch, output ready);
endinterface

interface bpv_rsp_if;
   logic valid;
   logic ready;
   logic path_ok;

   modport source (output valid, output path_ok, input ready);
   modport sink   (input valid, input path_ok, output ready);
endinterface

@@ sv/binding_path_validator_top.sv @@
`timescale 1ns / 1ps
// Top level of the binding path validator: input register, parse state
// machine and response register. Depends on bpv_pkg and the bpv_if interfaces.
//
//   channel    direction  payload            transfer happens when
//   req_chan   in         action, ch[7:0]    req_chan.valid && req_chan.ready
//   rsp_chan   out        path_ok            rsp_chan.valid && rsp_chan.ready
//
// Each request transfer is captured in an input register and evaluated in the
// following cycle by the parse state machine, so one item is taken per clock
// unless an end item stalls. A character item produces no response; an end
// item's response is loaded into the response register when the end item
// leaves the input register, and is held there until taken.
// The input register stalls only when it holds an end item while the response
// register is still full and not being taken; character items never stall.
// Reset is synchronous and active high; it empties both registers and returns
// the parser to the start of a path.
module binding_path_validator_top (
   input logic     clock,
   input logic     reset,
   bpv_req_if.sink req_chan,
   bpv_rsp_if.source rsp_chan
);
   import bpv_pkg::*;

   // Input register.
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_action_ff;
   logic [CH_W-1:0] s1_ch_ff;

   // Parser state.
   phase_type phase_ff, phase_in;
   logic      failed_ff, failed_in;

   // Response register.
   logic rsp_valid_ff, rsp_valid_in;
   logic path_ok_ff, path_ok_in;

   logic     req_take;
   logic     s1_advance;
   logic     end_done;
   step_type step;

   // The held item may move on unless it is an end item that cannot yet be
   // placed in the response register.
   assign s1_advance = s1_valid_ff &&
                       ((s1_action_ff == ACT_CHAR) || !rsp_valid_ff || rsp_chan.ready);
   assign end_done   = s1_advance && (s1_action_ff == ACT_END);

   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_action_ff <= req_chan.action;
         s1_ch_ff     <= req_chan.ch;
      end
   end

   // Transition table of the path grammar. A character that the grammar does
   // not allow from the current phase is flagged as illegal.
   always_comb begin
      step.legal = 1'b1;
      step.phase = phase_ff;
      case (phase_ff)
         PH_START: begin
            if (s1_ch_ff == CH_LOOP) begin
               step.phase = PH_DOLLAR;
            end else if (is_id_first(s1_ch_ff)) begin
               step.phase = PH_SEGMENT;
            end else begin
               step.legal = 1'b0;
            end
         end
         PH_DOLLAR, PH_AFTER_DOT: begin
            if (is_id_first(s1_ch_ff)) begin
               step.phase = PH_SEGMENT;
            end else begin
               step.legal = 1'b0;
            end
         end
         PH_SEGMENT: begin
            if (is_id_rest(s1_ch_ff)) begin
               step.phase = PH_SEGMENT;
            end else if (s1_ch_ff == CH_DOT) begin
               step.phase = PH_AFTER_DOT;
            end else if (s1_ch_ff == CH_OPEN) begin
               step.phase = PH_IDX_OPEN;
            end else begin
               step.legal = 1'b0;
            end
         end
         PH_IDX_OPEN: begin
            if (is_digit(s1_ch_ff)) begin
               step.phase = PH_IDX_DIGIT;
            end else if (is_id_first(s1_ch_ff)) begin
               step.phase = PH_IDX_IDENT;
            end else begin
               step.legal = 1'b0;
            end
         end
         PH_IDX_DIGIT: begin
            if (is_digit(s1_ch_ff)) begin
               step.phase = PH_IDX_DIGIT;
            end else if (s1_ch_ff == CH_CLOSE) begin
               step.phase = PH_CLOSED;
            end else begin
               step.legal = 1'b0;
            end
         end
         PH_IDX_IDENT: begin
            if (is_id_rest(s1_ch_ff)) begin
               step.phase = PH_IDX_IDENT;
            end else if (s1_ch_ff == CH_CLOSE) begin
               step.phase = PH_CLOSED;
            end else begin
               step.legal = 1'b0;
            end
         end
         PH_CLOSED: begin
            // After a closing bracket only a dot or another index may follow.
            if (s1_ch_ff == CH_DOT) begin
               step.phase = PH_AFTER_DOT;
            end else if (s1_ch_ff == CH_OPEN) begin
               step.phase = PH_IDX_OPEN;
            end else begin
               step.legal = 1'b0;
            end
         end
         default: begin
            step.legal = 1'b0;
         end
      endcase
   end

   // Next parser state and response. Once a path has failed, later characters
   // are ignored until its end item arrives.
   always_comb begin
      phase_in     = phase_ff;
      failed_in    = failed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      path_ok_in   = path_ok_ff;
      if (end_done) begin
         phase_in     = PH_START;
         failed_in    = 1'b0;
         rsp_valid_in = 1'b1;
         path_ok_in   = !failed_ff &&
                        ((phase_ff == PH_SEGMENT) || (phase_ff == PH_CLOSED));
      end else if (s1_advance && !failed_ff) begin
         if (step.legal) begin
            phase_in = step.phase;
         end else begin
            failed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      path_ok_ff <= path_ok_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.path_ok = path_ok_ff;

   // An end item always leaves the parser clean for the next path.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      end_done |=> (phase_ff == PH_START) && !failed_ff)
      else $error("parser not cleared after end of path");

   // A failed path keeps its phase until the end item.
   a_failed_holds: assert property (@(posedge clock) disable iff (reset)
      failed_ff && !end_done |=> $stable(phase_ff) && failed_ff)
      else $error("phase moved after failure");

   // Backpressure reaches the request side only through a stalled end item.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && (s1_action_ff == ACT_END) &&
                          rsp_valid_ff && !rsp_chan.ready)
      else $error("request stalled without a full response register");

endmodule

@@ tb/binding_path_validator_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for binding_path_validator_top: directed and random
// binding paths, predicted verdicts and randomized idling on both channels.
// Depends on bpv_pkg, the bpv_if interfaces and the block's top level.
module binding_path_validator_top_tb;
   import bpv_pkg::*;

   // One request transfer: either a path character or an end-of-path mark.
   typedef struct {
      logic       action;
      logic [7:0] ch;
   } path_item_type;

   localparam int unsigned ITEMS_PER_PHASE = 400;
   localparam int unsigned TAIL_CYCLES     = 20;

   logic clock;
   logic reset;

   bpv_req_if req_chan ();
   bpv_rsp_if rsp_chan ();

   binding_path_validator_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Items waiting to be driven, the path being assembled, and the verdicts
   // that the block still owes us, oldest first.
   path_item_type pending_q[$];
   logic [7:0]    path_buf[$];
   logic          verdict_q[$];

   // Idling percentages for the current phase of the run.
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned items_queued;
   int          errors;

   // Set at each rising edge when a request transfer took place there; the
   // driver reads it at the following falling edge to decide whether the
   // item on the channel has been consumed.
   logic req_xfer;

   // Our own copy of the parser state.
   phase_type cur_phase;
   logic      path_broken;

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Character classes and the phase transition of the path grammar.
   // An illegal character comes back with legal cleared.
   // ------------------------------------------------------------------
   function automatic step_type next_step(input phase_type ph, input logic [7:0] c);
      step_type st;
      logic     alpha;
      logic     num;
      logic     lead;
      logic     body;
      alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
      num   = (c >= 8'h30 && c <= 8'h39);
      lead  = alpha || (c == CH_UNDER);
      body  = lead || num;
      st.legal = 1'b1;
      st.phase = ph;
      case (ph)
         PH_START: begin
            if (c == CH_LOOP) st.phase = PH_DOLLAR;
            else if (lead) st.phase = PH_SEGMENT;
            else st.legal = 1'b0;
         end
         PH_DOLLAR, PH_AFTER_DOT: begin
            if (lead) st.phase = PH_SEGMENT;
            else st.legal = 1'b0;
         end
         PH_SEGMENT: begin
            if (body) st.phase = PH_SEGMENT;
            else if (c == CH_DOT) st.phase = PH_AFTER_DOT;
            else if (c == CH_OPEN) st.phase = PH_IDX_OPEN;
            else st.legal = 1'b0;
         end
         PH_IDX_OPEN: begin
            if (num) st.phase = PH_IDX_DIGIT;
            else if (lead) st.phase = PH_IDX_IDENT;
            else st.legal = 1'b0;
         end
         PH_IDX_DIGIT: begin
            if (num) st.phase = PH_IDX_DIGIT;
            else if (c == CH_CLOSE) st.phase = PH_CLOSED;
            else st.legal = 1'b0;
         end
         PH_IDX_IDENT: begin
            if (body) st.phase = PH_IDX_IDENT;
            else if (c == CH_CLOSE) st.phase = PH_CLOSED;
            else st.legal = 1'b0;
         end
         default: begin
            // After a closing bracket only a dot or another index may follow.
            if (c == CH_DOT) st.phase = PH_AFTER_DOT;
            else if (c == CH_OPEN) st.phase = PH_IDX_OPEN;
            else st.legal = 1'b0;
         end
      endcase
      return st;
   endfunction

   // ------------------------------------------------------------------
   // Path building helpers for the stimulus.
   // ------------------------------------------------------------------
   task automatic put_byte(input logic [7:0] c);
      path_buf.insert(path_buf.size(), c);
   endtask

   function automatic logic [7:0] ident_char(input logic lead);
      int unsigned r;
      r = $urandom_range(0, lead ? 52 : 62);
      if (r < 26) return 8'h41 + 8'(r);
      if (r < 52) return 8'h61 + 8'(r - 26);
      if (r == 52) return CH_UNDER;
      return 8'h30 + 8'(r - 53);
   endfunction

   task automatic add_ident(input int unsigned n);
      put_byte(ident_char(1'b1));
      for (int unsigned k = 1; k < n; k++) put_byte(ident_char(1'b0));
   endtask

   task automatic add_text(input string s);
      for (int k = 0; k < s.len(); k++) put_byte(s[k]);
   endtask

   // Moves the assembled path onto the pending queue and closes it with an
   // end mark whose character byte is random, as the block must ignore it.
   task automatic queue_path();
      path_item_type it;
      foreach (path_buf[k]) begin
         it.action = ACT_CHAR;
         it.ch     = path_buf[k];
         pending_q.insert(pending_q.size(), it);
      end
      it.action = ACT_END;
      it.ch     = 8'($urandom_range(0, 255));
      pending_q.insert(pending_q.size(), it);
      items_queued += path_buf.size() + 1;
      path_buf.delete();
   endtask

   // Builds a well-formed path with random content, then in a share of the
   // cases breaks it: a random byte, a cut, a stray punctuation mark or identifier
   // character, or pure noise. Cuts can leave an empty path or a dangling dot or bracket.
   task automatic build_path();
      int unsigned nseg;
      int unsigned nidx;
      int unsigned pos;
      int unsigned mode;
      int unsigned len;
      logic [7:0]  punct;
      path_buf.delete();
      if ($urandom_range(0, 4) == 0) put_byte(CH_LOOP);
      nseg = $urandom_range(1, 3);
      for (int unsigned sg = 0; sg < nseg; sg++) begin
         if (sg != 0) put_byte(CH_DOT);
         add_ident($urandom_range(1, 5));
         nidx = $urandom_range(0, 2);
         for (int unsigned k = 0; k < nidx; k++) begin
            put_byte(CH_OPEN);
            if ($urandom_range(0, 1) == 0) begin
               len = $urandom_range(1, 3);
               for (int unsigned d = 0; d < len; d++)
                  put_byte(8'h30 + 8'($urandom_range(0, 9)));
            end else begin
               add_ident($urandom_range(1, 4));
            end
            put_byte(CH_CLOSE);
         end
      end
      mode = $urandom_range(0, 9);
      pos  = $urandom_range(0, path_buf.size() - 1);
      case (mode)
         6: path_buf[pos] = 8'($urandom_range(0, 255));
         7: begin
            while (path_buf.size() > pos) path_buf.delete(path_buf.size() - 1);
         end
         8: begin
            case ($urandom_range(0, 4))
               0: punct = CH_LOOP;
               1: punct = CH_DOT;
               2: punct = CH_OPEN;
               3: punct = CH_CLOSE;
               default: punct = ident_char(1'b0);
            endcase
            path_buf.insert(pos, punct);
         end
         9: begin
            path_buf.delete();
            len = $urandom_range(0, 6);
            for (int unsigned k = 0; k < len; k++)
               put_byte(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endtask

   // Blocks until the channel has drained and every verdict has come back.
   task automatic wait_drained();
      while (pending_q.size() != 0 || req_chan.valid || verdict_q.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Request driver. A new item is put on the channel at a falling edge only
   // when the channel is empty or its item was taken at the last rising
   // edge, so valid gets exactly one assignment per step. While idle the
   // payload carries noise, which the block must not look at.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      path_item_type it;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_xfer) begin
         if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            it = pending_q.pop_front();
            req_chan.valid  <= 1'b1;
            req_chan.action <= it.action;
            req_chan.ch     <= it.ch;
         end else begin
            req_chan.valid  <= 1'b0;
            req_chan.action <= 1'($urandom_range(0, 1));
            req_chan.ch     <= 8'($urandom_range(0, 255));
         end
      end
   end

   // Response back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(0, 99) >= stall_pct);
   end

   // ------------------------------------------------------------------
   // Monitor and scoreboard. Responses are checked before this edge's
   // request is tracked, so a response can never be matched against a
   // verdict that was only predicted at the same edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      step_type st;
      logic     want;
      if (reset) begin
         req_xfer    = 1'b0;
         cur_phase   = PH_START;
         path_broken = 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, got path_ok=%0b",
                        $time, rsp_chan.path_ok);
               errors++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_chan.path_ok !== want) begin
                  $display("%0t: path_ok mismatch, expected %0b, got %0b",
                           $time, want, rsp_chan.path_ok);
                  errors++;
               end
            end
         end

         req_xfer = req_chan.valid && req_chan.ready;
         if (req_xfer) begin
            if (req_chan.action == ACT_CHAR) begin
               // Once a path has gone wrong, its remaining characters are ignored.
               if (!path_broken) begin
                  st = next_step(cur_phase, req_chan.ch);
                  if (st.legal) cur_phase = st.phase;
                  else path_broken = 1'b1;
               end
            end else begin
               verdict_q.insert(verdict_q.size(), !path_broken &&
                                (cur_phase == PH_SEGMENT || cur_phase == PH_CLOSED));
               cur_phase   = PH_START;
               path_broken = 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Run limit, far above the slowest legal run.
   // ------------------------------------------------------------------
   initial begin
      #2_000_000;
      $display("%0t: run limit reached with %0d verdicts outstanding",
               $time, verdict_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence: reset, directed paths, then four random phases with
   // different idling. Between phases the sender holds off until every
   // verdict has come back.
   // ------------------------------------------------------------------
   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.action = ACT_CHAR;
      req_chan.ch     = 8'h00;
      rsp_chan.ready  = 1'b0;
      req_xfer        = 1'b0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      items_queued    = 0;
      errors          = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed paths: the empty path, a lone loop marker and a proper
      // one, a full path with both index kinds, dangling endings, an empty
      // index, a letter after a closing bracket, a misplaced loop marker, a
      // mixed index, a leading digit, and characters after a failure.
      queue_path();
      add_text("$");                queue_path();
      add_text("$a");               queue_path();
      add_text("_Zz09.b[12][k_2]"); queue_path();
      add_text("a.");               queue_path();
      add_text("a[1");              queue_path();
      add_text("a[]");              queue_path();
      add_text("x[1]b");            queue_path();
      add_text("a$");               queue_path();
      add_text("a[1x]");            queue_path();
      add_text("9");                queue_path();
      add_text("a!b");              queue_path();
      // NUL and bytes with the top bit set are never legal.
      add_text("a"); put_byte(8'h00); queue_path();
      add_text("a"); put_byte(8'h80); queue_path();
      add_text("a"); put_byte(8'hFF); queue_path();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
         endcase
         while (items_queued < ITEMS_PER_PHASE * (ph + 1)) begin
            build_path();
            queue_path();
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
